>>> src/dlex_pkg.sv
// ----------------------------------------------------------------------------
// dlex_pkg: shared types and constants for the directive line lexer
// Byte classes, parse states, action table, keyword text and beat formats.
// ----------------------------------------------------------------------------
`default_nettype none

package dlex_pkg;

  // Default sizes of the word and argument stores
  localparam int KEYWORD_MAX_DEF   = 10;
  localparam int ARG_MATCH_MAX_DEF = 8;

  // Character codes the lexer cares about
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;

  // Keyword text, first character at index 0
  localparam int KW_INCLUDE_LEN    = 7;
  localparam int KW_INCLUDEDIR_LEN = 10;
  localparam int KW_INCLUDED_LEN   = 9;
  localparam int KW_UNIQUE_LEN     = 6;
  localparam int KW_MULTIPLE_LEN   = 8;

  localparam logic [7:0] KW_INCLUDE [KW_INCLUDE_LEN] =
    '{"i", "n", "c", "l", "u", "d", "e"};
  localparam logic [7:0] KW_INCLUDEDIR [KW_INCLUDEDIR_LEN] =
    '{"i", "n", "c", "l", "u", "d", "e", "d", "i", "r"};
  localparam logic [7:0] KW_INCLUDED [KW_INCLUDED_LEN] =
    '{"i", "n", "c", "l", "u", "d", "e", "d", ":"};
  localparam logic [7:0] KW_UNIQUE [KW_UNIQUE_LEN] =
    '{"u", "n", "i", "q", "u", "e"};
  localparam logic [7:0] KW_MULTIPLE [KW_MULTIPLE_LEN] =
    '{"m", "u", "l", "t", "i", "p", "l", "e"};

  // Directive codes
  localparam logic [1:0] DIR_NONE       = 2'd0;
  localparam logic [1:0] DIR_INCLUDE    = 2'd1;
  localparam logic [1:0] DIR_INCLUDEDIR = 2'd2;
  localparam logic [1:0] DIR_INCLUDED   = 2'd3;

  // Mark codes for an included: argument
  localparam logic [1:0] MARK_NONE     = 2'd0;
  localparam logic [1:0] MARK_UNIQUE   = 2'd1;
  localparam logic [1:0] MARK_MULTIPLE = 2'd2;

  // Status codes
  localparam logic [2:0] STAT_RUN         = 3'd0;
  localparam logic [2:0] STAT_DONE        = 3'd1;
  localparam logic [2:0] STAT_ERR_BANG    = 3'd2;
  localparam logic [2:0] STAT_ERR_UNKNOWN = 3'd3;
  localparam logic [2:0] STAT_ERR_ARG     = 3'd4;
  localparam logic [2:0] STAT_ERR_EXTRA   = 3'd5;

  typedef enum logic [2:0] {
    CLS_END   = 3'd0,
    CLS_NL    = 3'd1,
    CLS_BANG  = 3'd2,
    CLS_BLANK = 3'd3,
    CLS_OTHER = 3'd4
  } dlex_class_t;

  // Parse states; DONE and above are final
  typedef enum logic [3:0] {
    ST_LINE_START  = 4'd0,
    ST_TEXT        = 4'd1,
    ST_BANG        = 4'd2,
    ST_COMMENT     = 4'd3,
    ST_PRE_WORD    = 4'd4,
    ST_WORD        = 4'd5,
    ST_PRE_ARG     = 4'd6,
    ST_ARG         = 4'd7,
    ST_DONE        = 4'd8,
    ST_ERR_BANG    = 4'd9,
    ST_ERR_UNKNOWN = 4'd11,
    ST_ERR_ARG     = 4'd12,
    ST_ERR_EXTRA   = 4'd13
  } dlex_state_t;

  typedef struct packed {
    logic        echo;
    logic        append;
    logic        word_end;
    logic        arg_end;
    dlex_state_t nxt;
  } dlex_act_t;

  // Store control from the parser to a word or argument store
  typedef struct packed {
    logic append;
    logic clear;
  } dlex_store_ctl_t;

  typedef struct packed {
    logic hit_unique;
    logic hit_multiple;
  } dlex_arg_hit_t;

  // Input beat
  typedef struct packed {
    logic [7:0] in_byte;
    logic       file_start;
  } dlex_in_t;

  // Result beat
  typedef struct packed {
    logic        echo_valid;
    logic [7:0]  out_byte;
    logic        arg_valid;
    logic [1:0]  directive;
    logic        arg_end;
    logic [1:0]  mark;
    logic [31:0] line_number;
    logic [2:0]  status;
  } dlex_out_t;

  function automatic dlex_class_t byte_class(input logic [7:0] b);
    dlex_class_t cls;
    if (b == CH_NUL) begin
      cls = CLS_END;
    end else if (b == CH_LF) begin
      cls = CLS_NL;
    end else if (b == CH_BANG) begin
      cls = CLS_BANG;
    end else if (b inside {CH_TAB, CH_CR, CH_SPACE}) begin
      cls = CLS_BLANK;
    end else begin
      cls = CLS_OTHER;
    end
    return cls;
  endfunction

  function automatic dlex_act_t mk_act(input logic echo, input logic append,
                                       input logic word_end, input logic arg_end,
                                       input dlex_state_t nxt);
    dlex_act_t a;
    a.echo     = echo;
    a.append   = append;
    a.word_end = word_end;
    a.arg_end  = arg_end;
    a.nxt      = nxt;
    return a;
  endfunction

  // Action table: what to do with a byte of a given class in a given state
  function automatic dlex_act_t step_action(input dlex_state_t st, input dlex_class_t cls);
    dlex_act_t a;
    a = mk_act(1'b0, 1'b0, 1'b0, 1'b0, ST_DONE);
    case (st)
      ST_LINE_START: begin
        case (cls)
          CLS_END:  a = mk_act(1'b0, 1'b0, 1'b0, 1'b0, ST_DONE);
          CLS_NL:   a = mk_act(1'b1, 1'b0, 1'b0, 1'b0, ST_LINE_START);
          CLS_BANG: a = mk_act(1'b0, 1'b0, 1'b0, 1'b0, ST_BANG);
          default:  a = mk_act(1'b1, 1'b0, 1'b0, 1'b0, ST_TEXT);
        endcase
      end
      ST_TEXT: begin
        case (cls)
          CLS_END: a = mk_act(1'b0, 1'b0, 1'b0, 1'b0, ST_DONE);
          CLS_NL:  a = mk_act(1'b1, 1'b0, 1'b0, 1'b0, ST_LINE_START);
          default: a = mk_act(1'b1, 1'b0, 1'b0, 1'b0, ST_TEXT);
        endcase
      end
      ST_BANG: begin
        case (cls)
          CLS_END:   a = mk_act(1'b0, 1'b0, 1'b0, 1'b0, ST_DONE);
          CLS_NL:    a = mk_act(1'b0, 1'b0, 1'b0, 1'b0, ST_LINE_START);
          CLS_BANG:  a = mk_act(1'b0, 1'b0, 1'b0, 1'b0, ST_COMMENT);
          CLS_BLANK: a = mk_act(1'b0, 1'b0, 1'b0, 1'b0, ST_PRE_WORD);
          default:   a = mk_act(1'b0, 1'b1, 1'b0, 1'b0, ST_WORD);
        endcase
      end
      ST_COMMENT: begin
        case (cls)
          CLS_END: a = mk_act(1'b0, 1'b0, 1'b0, 1'b0, ST_DONE);
          CLS_NL:  a = mk_act(1'b0, 1'b0, 1'b0, 1'b0, ST_LINE_START);
          default: a = mk_act(1'b0, 1'b0, 1'b0, 1'b0, ST_COMMENT);
        endcase
      end
      ST_PRE_WORD: begin
        case (cls)
          CLS_BLANK: a = mk_act(1'b0, 1'b0, 1'b0, 1'b0, ST_PRE_WORD);
          CLS_OTHER: a = mk_act(1'b0, 1'b1, 1'b0, 1'b0, ST_WORD);
          default:   a = mk_act(1'b0, 1'b0, 1'b0, 1'b0, ST_ERR_BANG);
        endcase
      end
      ST_WORD: begin
        case (cls)
          CLS_BLANK: a = mk_act(1'b0, 1'b0, 1'b1, 1'b0, ST_PRE_ARG);
          CLS_OTHER: a = mk_act(1'b0, 1'b1, 1'b0, 1'b0, ST_WORD);
          default:   a = mk_act(1'b0, 1'b0, 1'b0, 1'b0, ST_ERR_BANG);
        endcase
      end
      ST_PRE_ARG: begin
        case (cls)
          CLS_BANG:  a = mk_act(1'b0, 1'b0, 1'b0, 1'b0, ST_ARG);
          CLS_BLANK: a = mk_act(1'b0, 1'b0, 1'b0, 1'b0, ST_PRE_ARG);
          CLS_OTHER: a = mk_act(1'b0, 1'b1, 1'b0, 1'b0, ST_ARG);
          default:   a = mk_act(1'b0, 1'b0, 1'b0, 1'b0, ST_ERR_BANG);
        endcase
      end
      ST_ARG: begin
        case (cls)
          CLS_END: a = mk_act(1'b0, 1'b0, 1'b0, 1'b1, ST_DONE);
          CLS_NL:  a = mk_act(1'b0, 1'b0, 1'b0, 1'b1, ST_LINE_START);
          default: a = mk_act(1'b0, 1'b1, 1'b0, 1'b0, ST_ARG);
        endcase
      end
      default: a = mk_act(1'b0, 1'b0, 1'b0, 1'b0, st);
    endcase
    return a;
  endfunction

  function automatic logic [2:0] status_of(input dlex_state_t st);
    logic [2:0] s;
    case (st)
      ST_DONE:        s = STAT_DONE;
      ST_ERR_BANG:    s = STAT_ERR_BANG;
      ST_ERR_UNKNOWN: s = STAT_ERR_UNKNOWN;
      ST_ERR_ARG:     s = STAT_ERR_ARG;
      ST_ERR_EXTRA:   s = STAT_ERR_EXTRA;
      default:        s = STAT_RUN;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

>>> src/dlex_word_unit.sv
// ----------------------------------------------------------------------------
// dlex_word_unit: directive word store and keyword match
// Collects the bytes of a bang-line word and matches it against the
// include, includedir and included: keywords.
// ----------------------------------------------------------------------------
`default_nettype none

module dlex_word_unit #(
  parameter int KEYWORD_MAX = dlex_pkg::KEYWORD_MAX_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire dlex_pkg::dlex_store_ctl_t ctl,
  input  wire logic [7:0]                data,
  output logic [1:0]                     kind
);

  localparam int LW = $clog2(KEYWORD_MAX + 2);
  localparam int IW = $clog2(KEYWORD_MAX);

  logic [7:0]    store [KEYWORD_MAX];
  logic [LW-1:0] length;
  logic          hit_inc;
  logic          hit_dir;
  logic          hit_ed;

  // Count word bytes, saturating one past the store depth
  always_ff @(posedge clk) begin
    if (rst) begin
      length <= '0;
    end else if (ctl.clear) begin
      length <= '0;
    end else if (ctl.append && (length <= LW'(KEYWORD_MAX))) begin
      length <= length + LW'(1);
    end
  end

  // Keep the first bytes of the word
  always_ff @(posedge clk) begin
    if (ctl.append && (length < LW'(KEYWORD_MAX))) begin
      store[length[IW-1:0]] <= data;
    end
  end

  // Compare the stored word with each keyword
  always_comb begin
    hit_inc = (length == LW'(dlex_pkg::KW_INCLUDE_LEN));
    for (int i = 0; i < dlex_pkg::KW_INCLUDE_LEN; i++) begin
      if (store[i] != dlex_pkg::KW_INCLUDE[i]) hit_inc = 1'b0;
    end
    hit_dir = (length == LW'(dlex_pkg::KW_INCLUDEDIR_LEN));
    for (int i = 0; i < dlex_pkg::KW_INCLUDEDIR_LEN; i++) begin
      if (store[i] != dlex_pkg::KW_INCLUDEDIR[i]) hit_dir = 1'b0;
    end
    hit_ed = (length == LW'(dlex_pkg::KW_INCLUDED_LEN));
    for (int i = 0; i < dlex_pkg::KW_INCLUDED_LEN; i++) begin
      if (store[i] != dlex_pkg::KW_INCLUDED[i]) hit_ed = 1'b0;
    end
  end

  always_comb begin
    if (hit_inc) begin
      kind = dlex_pkg::DIR_INCLUDE;
    end else if (hit_dir) begin
      kind = dlex_pkg::DIR_INCLUDEDIR;
    end else if (hit_ed) begin
      kind = dlex_pkg::DIR_INCLUDED;
    end else begin
      kind = dlex_pkg::DIR_NONE;
    end
  end

endmodule

`default_nettype wire

>>> src/dlex_arg_unit.sv
// ----------------------------------------------------------------------------
// dlex_arg_unit: directive argument store and mark match
// Collects argument bytes and checks them against unique and multiple.
// ----------------------------------------------------------------------------
`default_nettype none

module dlex_arg_unit #(
  parameter int ARG_MATCH_MAX = dlex_pkg::ARG_MATCH_MAX_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire dlex_pkg::dlex_store_ctl_t ctl,
  input  wire logic [7:0]                data,
  output dlex_pkg::dlex_arg_hit_t        hit
);

  localparam int LW = $clog2(ARG_MATCH_MAX + 2);
  localparam int IW = $clog2(ARG_MATCH_MAX);

  logic [7:0]    store [ARG_MATCH_MAX];
  logic [LW-1:0] length;

  // Count argument bytes, saturating one past the store depth
  always_ff @(posedge clk) begin
    if (rst) begin
      length <= '0;
    end else if (ctl.clear) begin
      length <= '0;
    end else if (ctl.append && (length <= LW'(ARG_MATCH_MAX))) begin
      length <= length + LW'(1);
    end
  end

  // Keep the first bytes of the argument
  always_ff @(posedge clk) begin
    if (ctl.append && (length < LW'(ARG_MATCH_MAX))) begin
      store[length[IW-1:0]] <= data;
    end
  end

  // Compare the stored argument with both marks
  always_comb begin
    hit.hit_unique = (length == LW'(dlex_pkg::KW_UNIQUE_LEN));
    for (int i = 0; i < dlex_pkg::KW_UNIQUE_LEN; i++) begin
      if (store[i] != dlex_pkg::KW_UNIQUE[i]) hit.hit_unique = 1'b0;
    end
    hit.hit_multiple = (length == LW'(dlex_pkg::KW_MULTIPLE_LEN));
    for (int i = 0; i < dlex_pkg::KW_MULTIPLE_LEN; i++) begin
      if (store[i] != dlex_pkg::KW_MULTIPLE[i]) hit.hit_multiple = 1'b0;
    end
  end

endmodule

`default_nettype wire

>>> src/dlex_ctrl.sv
// ----------------------------------------------------------------------------
// dlex_ctrl: parser state machine and line counter
// Steps the action table for one byte, drives the word and argument stores
// and builds the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module dlex_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      fire,
  input  wire dlex_pkg::dlex_in_t        item,
  input  wire logic [1:0]                word_kind,
  input  wire dlex_pkg::dlex_arg_hit_t   arg_hit,
  output dlex_pkg::dlex_store_ctl_t      word_ctl,
  output dlex_pkg::dlex_store_ctl_t      arg_ctl,
  output dlex_pkg::dlex_out_t            res
);

  dlex_pkg::dlex_state_t parse_state;
  dlex_pkg::dlex_state_t parse_state_next;
  logic [31:0]           line_count;
  logic [31:0]           line_count_next;
  logic [1:0]            directive_kind;
  logic [1:0]            directive_kind_next;
  logic                  included_seen;
  logic                  included_seen_next;

  dlex_pkg::dlex_state_t st_eff;
  dlex_pkg::dlex_state_t nxt;
  logic [31:0]           line_eff;
  logic [1:0]            kind_eff;
  logic                  seen_eff;
  dlex_pkg::dlex_act_t   act;

  // Hold parser state; advance on each processed beat
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_state    <= dlex_pkg::ST_LINE_START;
      line_count     <= 32'd1;
      directive_kind <= dlex_pkg::DIR_NONE;
      included_seen  <= 1'b0;
    end else if (fire) begin
      parse_state    <= parse_state_next;
      line_count     <= line_count_next;
      directive_kind <= directive_kind_next;
      included_seen  <= included_seen_next;
    end
  end

  // Step the table for the current byte
  always_comb begin
    // file_start restarts the parser ahead of this byte
    st_eff   = item.file_start ? dlex_pkg::ST_LINE_START : parse_state;
    line_eff = item.file_start ? 32'd1 : line_count;
    kind_eff = item.file_start ? dlex_pkg::DIR_NONE : directive_kind;
    seen_eff = item.file_start ? 1'b0 : included_seen;
    act      = dlex_pkg::step_action(st_eff, dlex_pkg::byte_class(item.in_byte));
    nxt      = act.nxt;

    parse_state_next    = st_eff;
    line_count_next     = line_eff;
    directive_kind_next = kind_eff;
    included_seen_next  = seen_eff;

    word_ctl.append = 1'b0;
    word_ctl.clear  = fire & item.file_start;
    arg_ctl.append  = 1'b0;
    arg_ctl.clear   = fire & item.file_start;

    res             = '0;
    res.out_byte    = item.in_byte;
    res.line_number = line_eff;

    if (st_eff >= dlex_pkg::ST_DONE) begin
      // Final state: hold and report status
      res.status = dlex_pkg::status_of(st_eff);
    end else begin
      res.echo_valid = act.echo;

      if (act.append) begin
        if (act.nxt == dlex_pkg::ST_WORD) begin
          word_ctl.append = fire;
        end else begin
          arg_ctl.append = fire;
          res.arg_valid  = 1'b1;
          res.directive  = kind_eff;
        end
      end else if (act.nxt == dlex_pkg::ST_ARG) begin
        res.directive = kind_eff;
      end

      // Resolve the directive word
      if (act.word_end) begin
        directive_kind_next = word_kind;
        res.directive       = word_kind;
        word_ctl.clear      = fire;
        if (word_kind == dlex_pkg::DIR_NONE) nxt = dlex_pkg::ST_ERR_UNKNOWN;
      end

      // Close the argument; check the included: mark
      if (act.arg_end) begin
        res.directive = kind_eff;
        arg_ctl.clear = fire;
        if (kind_eff == dlex_pkg::DIR_INCLUDED) begin
          if (seen_eff) begin
            nxt = dlex_pkg::ST_ERR_EXTRA;
          end else if (arg_hit.hit_unique) begin
            res.mark           = dlex_pkg::MARK_UNIQUE;
            included_seen_next = 1'b1;
          end else if (arg_hit.hit_multiple) begin
            res.mark           = dlex_pkg::MARK_MULTIPLE;
            included_seen_next = 1'b1;
          end else begin
            nxt = dlex_pkg::ST_ERR_ARG;
          end
        end
        if (nxt <= dlex_pkg::ST_DONE) res.arg_end = 1'b1;
      end

      res.status = dlex_pkg::status_of(nxt);

      // Advance the line count on a newline that raises no error
      if ((item.in_byte == dlex_pkg::CH_LF) && (nxt <= dlex_pkg::ST_DONE) &&
          (line_eff != '1)) begin
        line_count_next = line_eff + 32'd1;
      end

      parse_state_next = nxt;
    end
  end

endmodule

`default_nettype wire

>>> src/directive_line_lexer_top.sv
// An accepted byte passes the input register, then the result register.
// One byte per cycle unless result stalls; parser state is a one-register loop.
// The input register takes a new byte while a result waits, but only if empty.
// Reset clears the parser state, line count (to 1), store lengths and valids;
// the word and argument stores are not cleared.
// ----------------------------------------------------------------------------
// directive_line_lexer_top: byte-at-a-time directive line lexer
// Input register, parser with word/argument matchers, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module directive_line_lexer_top #(
  parameter int KEYWORD_MAX   = dlex_pkg::KEYWORD_MAX_DEF,
  parameter int ARG_MATCH_MAX = dlex_pkg::ARG_MATCH_MAX_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                item_valid,
  output logic                     item_stall,
  input  wire dlex_pkg::dlex_in_t  item,
  output logic                     result_valid,
  input  wire logic                result_stall,
  output dlex_pkg::dlex_out_t      result
);

  dlex_pkg::dlex_in_t        item_q;
  logic                      item_q_valid;
  logic                      advance;
  logic                      fire;
  logic [1:0]                word_kind;
  dlex_pkg::dlex_arg_hit_t   arg_hit;
  dlex_pkg::dlex_store_ctl_t word_ctl;
  dlex_pkg::dlex_store_ctl_t arg_ctl;
  dlex_pkg::dlex_out_t       res;

  // Result register frees up when empty or being taken
  assign advance    = ~result_valid | ~result_stall;
  assign fire       = item_q_valid & advance;
  assign item_stall = item_q_valid & ~advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
    end else if (item_valid && !item_stall) begin
      item_q_valid <= 1'b1;
    end else if (fire) begin
      item_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      item_q <= item;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fire) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result <= res;
    end
  end

  dlex_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .item      (item_q),
    .word_kind (word_kind),
    .arg_hit   (arg_hit),
    .word_ctl  (word_ctl),
    .arg_ctl   (arg_ctl),
    .res       (res)
  );

  dlex_word_unit #(
    .KEYWORD_MAX (KEYWORD_MAX)
  ) u_word (
    .clk  (clk),
    .rst  (rst),
    .ctl  (word_ctl),
    .data (item_q.in_byte),
    .kind (word_kind)
  );

  dlex_arg_unit #(
    .ARG_MATCH_MAX (ARG_MATCH_MAX)
  ) u_arg (
    .clk  (clk),
    .rst  (rst),
    .ctl  (arg_ctl),
    .data (item_q.in_byte),
    .hit  (arg_hit)
  );

endmodule

`default_nettype wire
